// ===== rtl/itrs_pkg.sv =====
`timescale 1ns / 1ps

package itrs_pkg;

    // Default word width and number base limits
    localparam int WORD_BITS_DEF = 32;
    localparam int RADIX_BITS    = 6;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_BITS-1:0] DECIMAL     = 6'd10;

    // ASCII codes used in the output run
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] TEN        = 8'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT,
        ST_TERM
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEL_SIGN,
        SEL_DIGIT,
        SEL_TERM
    } char_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      load;
        logic      step;
        logic      shift;
        char_sel_t sel;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic bad;
        logic neg;
        logic top_zero;
        logic count_one;
        logic step_last;
    } dp_status_t;

    // Map a digit value to its lower-case ASCII character
    function automatic logic [7:0] digit_to_ascii(input logic [RADIX_BITS-1:0] d);
        logic [7:0] wide;
        wide = {2'b00, d};
        if (wide < TEN)
        begin
            return CHAR_ZERO + wide;
        end
        return CHAR_A + wide - TEN;
    endfunction

endpackage

// ===== rtl/itrs_in_if.sv =====
`timescale 1ns / 1ps

interface itrs_in_if #(
    parameter int WORD_BITS = itrs_pkg::WORD_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] word;
    logic                 signed_mode;

    modport source (output valid, output word, output signed_mode, input ready);
    modport sink   (input valid, input word, input signed_mode, output ready);
endinterface

// ===== rtl/itrs_out_if.sv =====
`timescale 1ns / 1ps

interface itrs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;
    logic       bad_radix;

    modport source (output valid, output character, output last, output bad_radix,
                    input ready);
    modport sink   (input valid, input character, input last, input bad_radix,
                    output ready);
endinterface

// ===== rtl/itrs_ctrl.sv =====
`timescale 1ns / 1ps

module itrs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  itrs_pkg::dp_status_t status,
    output itrs_pkg::dp_cmd_t    cmd
);

    itrs_pkg::ctrl_state_t state_reg;
    itrs_pkg::ctrl_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itrs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through convert, skip of leading zeros and character output, or go straight to the NUL for a bad base
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            itrs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.bad ? itrs_pkg::ST_TERM : itrs_pkg::ST_CONVERT;
                end
            end
            itrs_pkg::ST_CONVERT:
            begin
                if (status.step_last)
                begin
                    state_next = itrs_pkg::ST_SKIP;
                end
            end
            itrs_pkg::ST_SKIP:
            begin
                if (!(status.top_zero && !status.count_one))
                begin
                    state_next = status.neg ? itrs_pkg::ST_SIGN : itrs_pkg::ST_DIGIT;
                end
            end
            itrs_pkg::ST_SIGN:
            begin
                if (out_ready)
                begin
                    state_next = itrs_pkg::ST_DIGIT;
                end
            end
            itrs_pkg::ST_DIGIT:
            begin
                if (out_ready && status.count_one)
                begin
                    state_next = itrs_pkg::ST_TERM;
                end
            end
            itrs_pkg::ST_TERM:
            begin
                if (out_ready)
                begin
                    state_next = itrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itrs_pkg::ST_IDLE;
            end
        endcase
    end

    // Drive handshakes and datapath commands
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd.load  = 1'b0;
        cmd.step  = 1'b0;
        cmd.shift = 1'b0;
        cmd.sel   = itrs_pkg::SEL_TERM;
        unique case (state_reg)
            itrs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            itrs_pkg::ST_CONVERT:
            begin
                cmd.step = 1'b1;
            end
            itrs_pkg::ST_SKIP:
            begin
                cmd.shift = status.top_zero && !status.count_one;
            end
            itrs_pkg::ST_SIGN:
            begin
                out_valid = 1'b1;
                cmd.sel   = itrs_pkg::SEL_SIGN;
            end
            itrs_pkg::ST_DIGIT:
            begin
                out_valid = 1'b1;
                cmd.sel   = itrs_pkg::SEL_DIGIT;
                cmd.shift = out_ready;
            end
            itrs_pkg::ST_TERM:
            begin
                out_valid = 1'b1;
                cmd.sel   = itrs_pkg::SEL_TERM;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/itrs_datapath.sv =====
`timescale 1ns / 1ps

module itrs_datapath #(
    parameter int WORD_BITS = itrs_pkg::WORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            radix_we,
    input  logic [itrs_pkg::RADIX_BITS-1:0] radix_wdata,
    input  logic [WORD_BITS-1:0]            word,
    input  logic                            signed_mode,
    input  itrs_pkg::dp_cmd_t               cmd,
    output itrs_pkg::dp_status_t            status,
    output logic [7:0]                      character,
    output logic                            last,
    output logic                            bad_radix
);

    localparam int RB = itrs_pkg::RADIX_BITS;
    localparam int SB = $clog2(2 * WORD_BITS - 1);
    localparam int CB = $clog2(WORD_BITS + 1);
    localparam logic [SB-1:0] STEP_FEED_END = SB'(WORD_BITS);
    localparam logic [SB-1:0] STEP_LAST     = SB'(2 * WORD_BITS - 2);
    localparam logic [CB-1:0] COUNT_FULL    = CB'(WORD_BITS);
    localparam logic [CB-1:0] COUNT_ONE     = CB'(1);

    logic [RB-1:0]        radix_reg;
    logic [WORD_BITS-1:0] mag_reg;
    logic                 neg_reg;
    logic [SB-1:0]        step_reg;
    logic [CB-1:0]        count_reg;

    // Digit cells, most significant at the top index, and the carry wave between them
    logic [RB-1:0] cell_reg  [WORD_BITS];
    logic          cvalid_reg[WORD_BITS-1];
    logic          carry_reg [WORD_BITS-1];

    logic                 bad;
    logic                 neg;
    logic [WORD_BITS-1:0] mag;
    logic                 feed;

    // Hold the number base
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= itrs_pkg::RADIX_RESET;
        end
        else if (radix_we)
        begin
            radix_reg <= radix_wdata;
        end
    end

    assign bad  = (radix_reg < itrs_pkg::RADIX_MIN) || (radix_reg > itrs_pkg::RADIX_MAX);
    assign neg  = signed_mode && (radix_reg == itrs_pkg::DECIMAL) && word[WORD_BITS-1];
    assign mag  = neg ? (~word + WORD_BITS'(1)) : word;
    assign feed = cmd.step && (step_reg < STEP_FEED_END);

    // Load the magnitude and feed it into the bottom cell, top bit first
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= mag;
            neg_reg <= neg;
        end
        else if (feed)
        begin
            mag_reg <= {mag_reg[WORD_BITS-2:0], 1'b0};
        end
    end

    // Count conversion steps and characters left in the cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            step_reg  <= '0;
            count_reg <= COUNT_FULL;
        end
        else
        begin
            if (cmd.step)
            begin
                step_reg <= step_reg + SB'(1);
            end
            if (cmd.shift)
            begin
                count_reg <= count_reg - CB'(1);
            end
        end
    end

    // Each cell doubles its digit and adds the carry in, reducing by the base
    for (genvar k = 0; k < WORD_BITS; k++)
    begin : g_cell
        logic          vin;
        logic          cin;
        logic [RB-1:0] shift_in;
        logic [RB:0]   dbl;
        logic          ge;
        logic [RB:0]   red;

        if (k == 0)
        begin : g_bottom
            assign vin      = feed;
            assign cin      = mag_reg[WORD_BITS-1];
            assign shift_in = '0;
        end
        else
        begin : g_upper
            assign vin      = cmd.step && cvalid_reg[k-1];
            assign cin      = carry_reg[k-1];
            assign shift_in = cell_reg[k-1];
        end

        assign dbl = {cell_reg[k], 1'b0} + {{RB{1'b0}}, cin};
        assign ge  = dbl >= {1'b0, radix_reg};
        assign red = ge ? (dbl - {1'b0, radix_reg}) : dbl;

        always_ff @(posedge clk)
        begin
            if (cmd.load)
            begin
                cell_reg[k] <= '0;
            end
            else if (vin)
            begin
                cell_reg[k] <= red[RB-1:0];
            end
            else if (cmd.shift)
            begin
                cell_reg[k] <= shift_in;
            end
        end

        if (k < WORD_BITS - 1)
        begin : g_wave
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cvalid_reg[k] <= 1'b0;
                    carry_reg[k]  <= 1'b0;
                end
                else if (cmd.load)
                begin
                    cvalid_reg[k] <= 1'b0;
                    carry_reg[k]  <= 1'b0;
                end
                else if (cmd.step)
                begin
                    cvalid_reg[k] <= vin;
                    carry_reg[k]  <= vin && ge;
                end
            end
        end
    end

    // Report status to the controller
    assign status.bad       = bad;
    assign status.neg       = neg_reg;
    assign status.top_zero  = (cell_reg[WORD_BITS-1] == '0);
    assign status.count_one = (count_reg == COUNT_ONE);
    assign status.step_last = (step_reg == STEP_LAST);

    // Select the outgoing character
    always_comb
    begin
        unique case (cmd.sel)
            itrs_pkg::SEL_SIGN:  character = itrs_pkg::CHAR_MINUS;
            itrs_pkg::SEL_DIGIT: character = itrs_pkg::digit_to_ascii(cell_reg[WORD_BITS-1]);
            itrs_pkg::SEL_TERM:  character = itrs_pkg::CHAR_NUL;
            default:             character = itrs_pkg::CHAR_NUL;
        endcase
    end

    assign last      = (cmd.sel == itrs_pkg::SEL_TERM);
    assign bad_radix = (cmd.sel == itrs_pkg::SEL_TERM) && bad;

endmodule

// ===== rtl/integer_to_radix_string.sv =====
`timescale 1ns / 1ps

// Integer to text converter in a programmable base (2 to 36).
// word_ch takes one item: a word and a signed_mode flag. char_ch returns its text
// as a run of ASCII items, most significant digit first, closed by a NUL item
// with last set. bad_radix is set on that NUL when the base is out of range, and
// then the NUL is the whole run. radix_we / radix_wdata write the base; write it
// only while no run is in flight.
// Operation: the word is shifted bit by bit into a row of WORD_BITS base-B digit
// cells, and the carry moves one cell per cycle. The leading zero cells are then
// shifted out at one per cycle, the block turns to output, and each character
// leaves at one per cycle while the receiver is ready, up to the closing NUL.
// A bad base gives the NUL in the cycle after acceptance.
// One word is in flight at a time; word_ch.ready is high only when idle.
// A stall on char_ch holds the current character and freezes the run.
// Reset sets the base to 10 and returns the block to idle.
module integer_to_radix_string #(
    parameter int WORD_BITS = itrs_pkg::WORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    itrs_in_if.sink                         word_ch,
    itrs_out_if.source                      char_ch,
    input  logic                            radix_we,
    input  logic [itrs_pkg::RADIX_BITS-1:0] radix_wdata
);

    itrs_pkg::dp_cmd_t    cmd;
    itrs_pkg::dp_status_t status;

    itrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (word_ch.valid),
        .in_ready  (word_ch.ready),
        .out_valid (char_ch.valid),
        .out_ready (char_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    itrs_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .word        (word_ch.word),
        .signed_mode (word_ch.signed_mode),
        .cmd         (cmd),
        .status      (status),
        .character   (char_ch.character),
        .last        (char_ch.last),
        .bad_radix   (char_ch.bad_radix)
    );

endmodule
